/* rtl/eqvr_pkg.sv */
// Shared types and constants for the Euler-angle quaternion vector rotator.
// No dependencies.
package eqvr_pkg;

  localparam int unsigned TRIG_ITERATIONS_DEF = 16;
  localparam int unsigned ATAN_DEPTH          = 30;
  localparam int unsigned ANGLE_W             = 16;
  localparam int unsigned VEC_W               = 24;
  localparam int unsigned QUAT_W              = 32;
  localparam int unsigned CFG_IDX_W           = 2;
  localparam int unsigned QUEUE_DEPTH         = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 2'd2;

  localparam logic signed [QUAT_W-1:0] ONE_Q30 = 32'sd1073741824;

  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic                     ready;
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

endpackage

/* rtl/eqvr_if.sv */
// Stream interfaces for input vectors and rotated vectors.
// Depends on eqvr_pkg.
interface eqvr_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [eqvr_pkg::VEC_W-1:0] vec_x;
  logic signed [eqvr_pkg::VEC_W-1:0] vec_y;
  logic signed [eqvr_pkg::VEC_W-1:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface eqvr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [eqvr_pkg::VEC_W-1:0] rot_x;
  logic signed [eqvr_pkg::VEC_W-1:0] rot_y;
  logic signed [eqvr_pkg::VEC_W-1:0] rot_z;
  modport source (output valid, rot_x, rot_y, rot_z, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, output ready);
endinterface

/* rtl/eqvr_front.sv */
// Front end: accepts input words into a short queue.
// Depends on eqvr_pkg and eqvr_if.
module eqvr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  eqvr_in_if.sink           vec_in,
  input  logic              pop_i,
  output logic              valid_o,
  output eqvr_pkg::vec_t    data_o
);

  localparam int unsigned PW = $clog2(eqvr_pkg::QUEUE_DEPTH);

  eqvr_pkg::vec_t mem_q [eqvr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    cnt_q;
  logic           push;

  assign vec_in.ready = (cnt_q != (PW+1)'(eqvr_pkg::QUEUE_DEPTH));
  assign push         = vec_in.valid && vec_in.ready;
  assign valid_o      = (cnt_q != '0);
  assign data_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{x: vec_in.vec_x, y: vec_in.vec_y, z: vec_in.vec_z};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop_i);
    end
  end

endmodule

/* rtl/eqvr_quat.sv */
// Quaternion builder: shared CORDIC for the three half angles, then a
// shared multiplier sequence forming w, x, y, z. Depends on eqvr_pkg.
module eqvr_quat #(
  parameter int unsigned TRIG_ITERATIONS = eqvr_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                restart_i,
  input  logic signed [eqvr_pkg::ANGLE_W-1:0] ang_x_i,
  input  logic signed [eqvr_pkg::ANGLE_W-1:0] ang_y_i,
  input  logic signed [eqvr_pkg::ANGLE_W-1:0] ang_z_i,
  output eqvr_pkg::quat_t                     quat_o
);

  localparam int unsigned NITER = (TRIG_ITERATIONS > eqvr_pkg::ATAN_DEPTH) ?
                                  eqvr_pkg::ATAN_DEPTH : TRIG_ITERATIONS;
  localparam logic signed [34:0] DEG_TO_RAD = 35'sd9595049034;
  localparam logic signed [33:0] GAIN       = 34'sh26DD3B6A;
  localparam logic signed [16:0] HALF_90    = 17'sd11520;
  localparam logic signed [16:0] HALF_180   = 17'sd23040;
  localparam logic signed [33:0] LIM        = 34'sd1073741824;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_ITER = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;

  logic [2:0]         st_q;
  logic [1:0]         ax_q;
  logic [4:0]         it_q;
  logic [3:0]         step_q;
  logic               neg_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic signed [31:0] sin_q [3];
  logic signed [31:0] cos_q [3];
  logic signed [31:0] mp_q [12];
  eqvr_pkg::quat_t    quat_q;

  // half-angle reduction and radian conversion
  logic signed [16:0] ang, h;
  logic               neg;
  logic signed [50:0] zprod;
  always_comb begin
    case (ax_q)
      2'd0:    ang = 17'(ang_x_i);
      2'd1:    ang = 17'(ang_y_i);
      default: ang = 17'(ang_z_i);
    endcase
    neg = 1'b0;
    h   = ang;
    if (ang > HALF_90) begin
      h = ang - HALF_180; neg = 1'b1;
    end else if (ang < -HALF_90) begin
      h = ang + HALF_180; neg = 1'b1;
    end
    zprod = 51'(h) * 51'(DEG_TO_RAD) + 51'sd32768;
  end

  // one CORDIC micro-rotation
  logic signed [33:0] dx, dy, at, xn, yn, zn, xs, ys, cc, sc;
  always_comb begin
    dx = y_q >>> it_q;
    dy = x_q >>> it_q;
    at = $signed({2'b00, eqvr_pkg::ATAN_TAB[it_q]});
    if (!z_q[33]) begin
      xn = x_q - dx; yn = y_q + dy; zn = z_q - at;
    end else begin
      xn = x_q + dx; yn = y_q - dy; zn = z_q + at;
    end
    xs = neg_q ? -xn : xn;
    ys = neg_q ? -yn : yn;
    cc = (xs > LIM) ? LIM : ((xs < -LIM) ? -LIM : xs);
    sc = (ys > LIM) ? LIM : ((ys < -LIM) ? -LIM : ys);
  end

  // shared Q1.30 multiplier; index 0..2 = x,y,z axes
  logic signed [31:0] ma, mb;
  logic signed [63:0] mfull;
  always_comb begin
    case (step_q)
      4'd0:    begin ma = cos_q[2]; mb = cos_q[1]; end
      4'd1:    begin ma = sin_q[2]; mb = sin_q[1]; end
      4'd2:    begin ma = cos_q[2]; mb = sin_q[1]; end
      4'd3:    begin ma = sin_q[2]; mb = cos_q[1]; end
      4'd4:    begin ma = mp_q[0];  mb = cos_q[0]; end
      4'd5:    begin ma = mp_q[1];  mb = sin_q[0]; end
      4'd6:    begin ma = mp_q[0];  mb = sin_q[0]; end
      4'd7:    begin ma = mp_q[1];  mb = cos_q[0]; end
      4'd8:    begin ma = mp_q[2];  mb = cos_q[0]; end
      4'd9:    begin ma = mp_q[3];  mb = sin_q[0]; end
      4'd10:   begin ma = mp_q[3];  mb = cos_q[0]; end
      default: begin ma = mp_q[2];  mb = sin_q[0]; end
    endcase
    mfull = 64'(ma) * 64'(mb) + 64'sd536870912;
  end

  function automatic logic signed [31:0] clampq(input logic signed [32:0] v);
    logic signed [32:0] lim;
    lim = 33'sd1073741824;
    if (v > lim)       clampq = 32'(lim);
    else if (v < -lim) clampq = 32'(-lim);
    else               clampq = 32'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_LOAD: begin
        x_q   <= GAIN;
        y_q   <= '0;
        z_q   <= zprod[49:16];
        neg_q <= neg;
      end
      ST_ITER: begin
        x_q <= xn;
        y_q <= yn;
        z_q <= zn;
        if (it_q == 5'(NITER - 1)) begin
          cos_q[ax_q] <= 32'(cc);
          sin_q[ax_q] <= 32'(sc);
        end
      end
      ST_MUL:  mp_q[step_q] <= mfull[61:30];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      ax_q   <= '0;
      it_q   <= '0;
      step_q <= '0;
      quat_q <= '{ready: 1'b0, w: eqvr_pkg::ONE_Q30, x: '0, y: '0, z: '0};
    end else if (restart_i) begin
      st_q         <= ST_IDLE;
      quat_q.ready <= 1'b0;
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (!quat_q.ready) begin
            st_q <= ST_LOAD;
            ax_q <= '0;
          end
        end
        ST_LOAD: begin
          st_q <= ST_ITER;
          it_q <= '0;
        end
        ST_ITER: begin
          if (it_q == 5'(NITER - 1)) begin
            if (ax_q == 2'd2) begin
              st_q   <= ST_MUL;
              step_q <= '0;
            end else begin
              ax_q <= ax_q + 1'b1;
              st_q <= ST_LOAD;
            end
          end else begin
            it_q <= it_q + 1'b1;
          end
        end
        ST_MUL: begin
          if (step_q == 4'd11) st_q <= ST_SUM;
          else                 step_q <= step_q + 1'b1;
        end
        ST_SUM: begin
          quat_q.w     <= clampq(33'(mp_q[4]) + 33'(mp_q[5]));
          quat_q.x     <= clampq(33'(mp_q[6]) - 33'(mp_q[7]));
          quat_q.y     <= clampq(33'(mp_q[8]) + 33'(mp_q[9]));
          quat_q.z     <= clampq(33'(mp_q[10]) - 33'(mp_q[11]));
          quat_q.ready <= 1'b1;
          st_q         <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign quat_o = quat_q;

endmodule

/* rtl/eqvr_back.sv */
// Back end: five-stage rotation pipeline v + 2w(q x v) + 2q x (q x v),
// the last stage being the output register. Depends on eqvr_pkg and eqvr_if.
module eqvr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eqvr_pkg::quat_t   quat_i,
  input  logic              valid_i,
  input  eqvr_pkg::vec_t    data_i,
  output logic              pop_o,
  eqvr_out_if.source        rot_out
);

  logic               adv;
  logic [3:0]         vld_q;
  logic               out_vld_q;
  eqvr_pkg::vec_t     v1_q, v2_q, v3_q, v4_q;
  logic signed [55:0] p1_q [6];
  logic signed [25:0] uv_q [3];
  logic signed [57:0] p3_q [9];
  logic signed [26:0] uuv_q [3];
  logic signed [27:0] t1_q [3];
  logic signed [23:0] rx_q, ry_q, rz_q;

  assign adv   = !out_vld_q || rot_out.ready;
  assign pop_o = adv && valid_i && quat_i.ready;

  logic signed [56:0] s2 [3];
  logic signed [58:0] s4 [3];
  logic signed [58:0] s4t [3];
  logic signed [29:0] r [3];
  logic signed [23:0] sat [3];
  always_comb begin
    s2[0] = 57'(p1_q[0]) - 57'(p1_q[1]) + 57'sd536870912;
    s2[1] = 57'(p1_q[2]) - 57'(p1_q[3]) + 57'sd536870912;
    s2[2] = 57'(p1_q[4]) - 57'(p1_q[5]) + 57'sd536870912;
    s4[0] = 59'(p3_q[0]) - 59'(p3_q[1]) + 59'sd536870912;
    s4[1] = 59'(p3_q[2]) - 59'(p3_q[3]) + 59'sd536870912;
    s4[2] = 59'(p3_q[4]) - 59'(p3_q[5]) + 59'sd536870912;
    for (int j = 0; j < 3; j++) begin
      s4t[j] = 59'(p3_q[6+j]) + 59'sd268435456;
    end
    r[0] = 30'(v4_q.x) + 30'(t1_q[0]) + 30'(uuv_q[0]) * 30'sd2;
    r[1] = 30'(v4_q.y) + 30'(t1_q[1]) + 30'(uuv_q[1]) * 30'sd2;
    r[2] = 30'(v4_q.z) + 30'(t1_q[2]) + 30'(uuv_q[2]) * 30'sd2;
    for (int j = 0; j < 3; j++) begin
      if (r[j] > 30'sd8388607)       sat[j] = 24'sh7FFFFF;
      else if (r[j] < -30'sd8388608) sat[j] = -24'sh800000;
      else                           sat[j] = 24'(r[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1_q    <= data_i;
      p1_q[0] <= 56'(quat_i.y) * 56'(data_i.z);
      p1_q[1] <= 56'(quat_i.z) * 56'(data_i.y);
      p1_q[2] <= 56'(quat_i.z) * 56'(data_i.x);
      p1_q[3] <= 56'(quat_i.x) * 56'(data_i.z);
      p1_q[4] <= 56'(quat_i.x) * 56'(data_i.y);
      p1_q[5] <= 56'(quat_i.y) * 56'(data_i.x);
      v2_q <= v1_q;
      for (int j = 0; j < 3; j++) uv_q[j] <= s2[j][55:30];
      v3_q    <= v2_q;
      p3_q[0] <= 58'(quat_i.y) * 58'(uv_q[2]);
      p3_q[1] <= 58'(quat_i.z) * 58'(uv_q[1]);
      p3_q[2] <= 58'(quat_i.z) * 58'(uv_q[0]);
      p3_q[3] <= 58'(quat_i.x) * 58'(uv_q[2]);
      p3_q[4] <= 58'(quat_i.x) * 58'(uv_q[1]);
      p3_q[5] <= 58'(quat_i.y) * 58'(uv_q[0]);
      for (int j = 0; j < 3; j++) p3_q[6+j] <= 58'(quat_i.w) * 58'(uv_q[j]);
      v4_q <= v3_q;
      for (int j = 0; j < 3; j++) begin
        uuv_q[j] <= s4[j][56:30];
        t1_q[j]  <= s4t[j][56:29];
      end
      rx_q <= sat[0];
      ry_q <= sat[1];
      rz_q <= sat[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[2:0], pop_o};
      out_vld_q <= vld_q[3];
    end
  end

  assign rot_out.valid = out_vld_q;
  assign rot_out.rot_x = rx_q;
  assign rot_out.rot_y = ry_q;
  assign rot_out.rot_z = rz_q;

endmodule

/* rtl/euler_quaternion_vector_rotate_core.sv */
// Top level of the Euler-angle quaternion vector rotator.
// Depends on eqvr_pkg, eqvr_if, eqvr_front, eqvr_quat, eqvr_back.
//
//  channel  | dir | word                   | handshake
//  vec_in   | in  | vec_x, vec_y, vec_z    | valid/ready
//  rot_out  | out | rot_x, rot_y, rot_z    | valid/ready
//  cfg      | in  | cfg_idx_i, cfg_wdata_i | cfg_we_i, no wait
//
// One word per cycle once the quaternion is ready, unless the output stalls.
// After reset or an angle write the quaternion is rebuilt by the one shared
// CORDIC, with N = min(TRIG_ITERATIONS, 30) iterations, and the multiplier.
// Words arriving meanwhile wait in the 4-deep input queue.
// An output stall holds the pipeline; the queue keeps accepting until full.
module euler_quaternion_vector_rotate_core #(
  parameter int unsigned TRIG_ITERATIONS = eqvr_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  eqvr_in_if.sink                               vec_in,
  eqvr_out_if.source                            rot_out,
  input  logic                                  cfg_we_i,
  input  logic [eqvr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [eqvr_pkg::ANGLE_W-1:0]          cfg_wdata_i
);

  logic signed [eqvr_pkg::ANGLE_W-1:0] ang_x_q, ang_y_q, ang_z_q;
  logic            restart, q_valid, pop;
  eqvr_pkg::vec_t  q_data;
  eqvr_pkg::quat_t quat;

  assign restart = cfg_we_i && (cfg_idx_i == eqvr_pkg::REG_ANGLE_X ||
                                cfg_idx_i == eqvr_pkg::REG_ANGLE_Y ||
                                cfg_idx_i == eqvr_pkg::REG_ANGLE_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        eqvr_pkg::REG_ANGLE_X: ang_x_q <= cfg_wdata_i;
        eqvr_pkg::REG_ANGLE_Y: ang_y_q <= cfg_wdata_i;
        eqvr_pkg::REG_ANGLE_Z: ang_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  eqvr_front u_front (
    .clk_i, .rst_ni, .vec_in,
    .pop_i(pop), .valid_o(q_valid), .data_o(q_data)
  );

  eqvr_quat #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_quat (
    .clk_i, .rst_ni, .restart_i(restart),
    .ang_x_i(ang_x_q), .ang_y_i(ang_y_q), .ang_z_i(ang_z_q),
    .quat_o(quat)
  );

  eqvr_back u_back (
    .clk_i, .rst_ni, .quat_i(quat), .valid_i(q_valid), .data_i(q_data),
    .pop_o(pop), .rot_out
  );

  a_no_pop_unready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !quat.ready |-> !pop) else $error("word issued before quaternion built");
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> !quat.ready) else $error("angle write did not clear quaternion");
  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid) else $error("pop from empty queue");
  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quat.ready |-> (quat.w <= eqvr_pkg::ONE_Q30 && quat.w >= -eqvr_pkg::ONE_Q30))
    else $error("quaternion w out of range");

endmodule

/* bench/euler_quaternion_vector_rotate_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for euler_quaternion_vector_rotate_core: angle settings, streamed vectors,
// a built-in fixed-point predictor and random valid/ready idling.
// Depends on eqvr_pkg, eqvr_if and the core RTL.
module euler_quaternion_vector_rotate_core_tb;

  localparam int unsigned TRIG_N     = (eqvr_pkg::TRIG_ITERATIONS_DEF > 30) ? 30 :
                                       eqvr_pkg::TRIG_ITERATIONS_DEF;
  localparam int          SETTLE     = 24;
  localparam int          CYCLE_MAX  = 600000;
  localparam int          HOLD_LEN   = 400;
  localparam logic [eqvr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [eqvr_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [eqvr_pkg::ANGLE_W-1:0] cfg_wdata_i = '0;

  eqvr_in_if  vin();
  eqvr_out_if rout();

  euler_quaternion_vector_rotate_core DUT (
    .clk_i, .rst_ni, .vec_in(vin), .rot_out(rout),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [eqvr_pkg::ANGLE_W-1:0] ang_q [3];
  longint qw, qx, qy, qz;
  bit     quat_valid;

  eqvr_pkg::vec_t vec_pend_q [$];
  eqvr_pkg::vec_t rot_exp_q  [$];
  int   send_idle, recv_idle;
  int   mism_cnt, cyc_cnt;
  bit   in_took, hold_req, hold_done;
  int   hold_cnt;

  function automatic longint rmul(longint a, longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic half_sincos(input logic signed [eqvr_pkg::ANGLE_W-1:0] ang,
                             output longint s, output longint c);
    longint h, x, y, z, dx, dy;
    bit neg;
    h = ang; x = 64'sh26DD3B6A; y = 0; neg = 0;
    if (h > 11520) begin h -= 23040; neg = 1; end
    else if (h < -11520) begin h += 23040; neg = 1; end
    z = (h * 64'sd9595049034 + (longint'(1) <<< 15)) >>> 16;
    for (int i = 0; i < TRIG_N; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin x -= dx; y += dy; z -= longint'(eqvr_pkg::ATAN_TAB[i]); end
      else begin x += dx; y -= dy; z += longint'(eqvr_pkg::ATAN_TAB[i]); end
    end
    if (neg) begin x = -x; y = -y; end
    c = clip(x, -(longint'(1) <<< 30), longint'(1) <<< 30);
    s = clip(y, -(longint'(1) <<< 30), longint'(1) <<< 30);
  endtask

  task automatic rebuild_quat();
    longint sx, cx, sy, cy, sz, cz, czcy, szsy, czsy, szcy, one;
    one = longint'(1) <<< 30;
    half_sincos(ang_q[0], sx, cx);
    half_sincos(ang_q[1], sy, cy);
    half_sincos(ang_q[2], sz, cz);
    czcy = rmul(cz, cy); szsy = rmul(sz, sy);
    czsy = rmul(cz, sy); szcy = rmul(sz, cy);
    qw = clip(rmul(czcy, cx) + rmul(szsy, sx), -one, one);
    qx = clip(rmul(czcy, sx) - rmul(szsy, cx), -one, one);
    qy = clip(rmul(czsy, cx) + rmul(szcy, sx), -one, one);
    qz = clip(rmul(szcy, cx) - rmul(czsy, sx), -one, one);
    quat_valid = 1;
  endtask

  task automatic rotate_vec(input eqvr_pkg::vec_t v, output eqvr_pkg::vec_t r);
    longint a [3], b [3], u [3], uu [3], t;
    longint rnd30;
    rnd30 = longint'(1) <<< 29;
    if (!quat_valid) rebuild_quat();
    a[0] = qx; a[1] = qy; a[2] = qz;
    b[0] = v.x; b[1] = v.y; b[2] = v.z;
    u[0] = (a[1] * b[2] - a[2] * b[1] + rnd30) >>> 30;
    u[1] = (a[2] * b[0] - a[0] * b[2] + rnd30) >>> 30;
    u[2] = (a[0] * b[1] - a[1] * b[0] + rnd30) >>> 30;
    uu[0] = (a[1] * u[2] - a[2] * u[1] + rnd30) >>> 30;
    uu[1] = (a[2] * u[0] - a[0] * u[2] + rnd30) >>> 30;
    uu[2] = (a[0] * u[1] - a[1] * u[0] + rnd30) >>> 30;
    for (int j = 0; j < 3; j++) begin
      t = b[j] + ((qw * u[j] + (longint'(1) <<< 28)) >>> 29)
          + (((uu[j] <<< 30) + (longint'(1) <<< 28)) >>> 29);
      b[j] = clip(t, -64'sd8388608, 64'sd8388607);
    end
    r.x = b[0][eqvr_pkg::VEC_W-1:0];
    r.y = b[1][eqvr_pkg::VEC_W-1:0];
    r.z = b[2][eqvr_pkg::VEC_W-1:0];
  endtask

  // driver: inputs move on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      vin.valid <= 1'b0;
    end else if (!vin.valid || in_took) begin
      if (vec_pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        eqvr_pkg::vec_t w;
        w = vec_pend_q.pop_front();
        vin.vec_x <= w.x; vin.vec_y <= w.y; vin.vec_z <= w.z;
        vin.valid <= 1'b1;
      end else begin
        vin.valid <= 1'b0;
      end
    end
  end

  // receiver with a one-time long hold-off
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
      rout.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      rout.ready <= 1'b0;
    end else begin
      rout.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // input acceptance and result check on the rising edge
  always @(posedge clk_i) begin
    in_took <= vin.valid && vin.ready && rst_ni;
    if (rst_ni && vin.valid && vin.ready) begin
      eqvr_pkg::vec_t vi, ro;
      vi.x = vin.vec_x; vi.y = vin.vec_y; vi.z = vin.vec_z;
      rotate_vec(vi, ro);
      rot_exp_q.push_back(ro);
    end
    if (rst_ni && rout.valid && rout.ready) begin
      if (rot_exp_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected word %h %h %h", rout.rot_x, rout.rot_y,
                                     rout.rot_z);
      end else begin
        eqvr_pkg::vec_t e;
        e = rot_exp_q.pop_front();
        if (e.x !== rout.rot_x || e.y !== rout.rot_y || e.z !== rout.rot_z) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("rotated word: expected %h %h %h, got %h %h %h", e.x, e.y, e.z,
                     rout.rot_x, rout.rot_y, rout.rot_z);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_MAX) begin
      $display("euler_quaternion_vector_rotate_core: mismatch");
      $finish;
    end
  end

  // checked on the rising edge, where the driver never moves
  task automatic wait_drained();
    while (vec_pend_q.size() > 0 || vin.valid || rot_exp_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_angle(input logic [eqvr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [eqvr_pkg::ANGLE_W-1:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx != REG_UNUSED) begin
      ang_q[idx] = val;
      quat_valid = 0;
    end
    @(negedge clk_i);
  endtask

  function automatic eqvr_pkg::vec_t rand_vec();
    eqvr_pkg::vec_t v;
    if ($urandom_range(3) == 0) begin
      v.x = 24'($urandom); v.y = 24'($urandom); v.z = 24'($urandom);
    end else begin
      v.x = 24'($signed($urandom_range(131072)) - 65536);
      v.y = 24'($signed($urandom_range(131072)) - 65536);
      v.z = 24'($signed($urandom_range(131072)) - 65536);
    end
    return v;
  endfunction

  function automatic logic [eqvr_pkg::ANGLE_W-1:0] rand_angle();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($signed($urandom_range(46080)) - 23040);
      default: return 16'($signed($urandom_range(2000)) - 1000 +
                          11520 * $signed($urandom_range(4) - 2));
    endcase
  endfunction

  localparam logic [eqvr_pkg::ANGLE_W-1:0] ANG_EDGE [12] = '{
    16'h0000, 16'sd23040, -16'sd23040, 16'sd11520, 16'sd11521, -16'sd11520,
    -16'sd11521, 16'h7FFF, 16'h8000, 16'sd5760, 16'hFFFF, 16'sd64
  };

  initial begin
    eqvr_pkg::vec_t v;
    vin.valid = 1'b0; vin.vec_x = '0; vin.vec_y = '0; vin.vec_z = '0;
    rout.ready = 1'b0;
    ang_q[0] = '0; ang_q[1] = '0; ang_q[2] = '0;
    qw = longint'(1) <<< 30; qx = 0; qy = 0; qz = 0; quat_valid = 0;
    mism_cnt = 0; cyc_cnt = 0; in_took = 0; hold_req = 0; hold_done = 0; hold_cnt = 0;
    send_idle = 37; recv_idle = 69;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // field extremes under the reset angles first, then under a tilted rotation
    for (int k = 0; k < 2; k++) begin
      if (k == 1) begin
        wait_drained();
        write_angle(eqvr_pkg::REG_ANGLE_X, 16'sd1920);
        write_angle(eqvr_pkg::REG_ANGLE_Y, -16'sd3000);
        write_angle(eqvr_pkg::REG_ANGLE_Z, 16'sd7777);
      end
      v = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}; vec_pend_q.push_back(v);
      v = '{24'sh800000, 24'sh800000, 24'sh800000}; vec_pend_q.push_back(v);
      v = '{24'sh7FFFFF, 24'sh800000, 24'sh000000}; vec_pend_q.push_back(v);
      v = '{24'sh000000, 24'sh000000, 24'sh000000}; vec_pend_q.push_back(v);
      v = '{24'sh010000, 24'sh000000, 24'sh000000}; vec_pend_q.push_back(v);
      v = '{24'sh000000, 24'sh010000, 24'sh000000}; vec_pend_q.push_back(v);
      v = '{24'sh000000, 24'sh000000, 24'shFF0000}; vec_pend_q.push_back(v);
      v = '{24'shFFFFFF, 24'sh000001, 24'shFFFFFF}; vec_pend_q.push_back(v);
      v = '{24'sh800000, 24'sh7FFFFF, 24'sh555555}; vec_pend_q.push_back(v);
      v = '{24'sh2AAAAA, 24'shAAAAAA, 24'sh7FFFFF}; vec_pend_q.push_back(v);
    end

    // angle boundaries, then random settings with an unknown-index write and a long hold-off
    for (int ph = 0; ph < 14; ph++) begin
      wait_drained();
      if (ph == 5) begin send_idle = 69; recv_idle = 37; end
      if (ph == 10) begin send_idle = 0; recv_idle = 0; end
      if (ph < 4) begin
        for (int r = 0; r < 3; r++)
          write_angle(r[eqvr_pkg::CFG_IDX_W-1:0], ANG_EDGE[(ph * 3 + r) % 12]);
      end else begin
        if ($urandom_range(1)) write_angle(eqvr_pkg::REG_ANGLE_X, rand_angle());
        if ($urandom_range(1)) write_angle(eqvr_pkg::REG_ANGLE_Y, rand_angle());
        write_angle(eqvr_pkg::REG_ANGLE_Z, rand_angle());
      end
      if (ph == 6) write_angle(REG_UNUSED, 16'h1234);
      if (ph == 8) hold_req = 1'b1;
      for (int n = 0; n < 115; n++) vec_pend_q.push_back(rand_vec());
    end

    wait_drained();
    if (mism_cnt == 0) begin
      $display("euler_quaternion_vector_rotate_core: match");
    end else begin
      $display("euler_quaternion_vector_rotate_core: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/eqvr_pkg.sv
rtl/eqvr_if.sv
rtl/eqvr_front.sv
rtl/eqvr_quat.sv
rtl/eqvr_back.sv
rtl/euler_quaternion_vector_rotate_core.sv
bench/euler_quaternion_vector_rotate_core_tb.sv
